[sv/pfma_pkg.sv]
// shared types, codes and defaults of the prime field modular alu
package pfma_pkg;

    // default datapath width
    localparam int unsigned FIELD_WIDTH = 64;

    // command codes carried in tuser
    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_MUL  = 4'd2;
    localparam logic [3:0] CMD_DIV  = 4'd3;
    localparam logic [3:0] CMD_NEG  = 4'd4;
    localparam logic [3:0] CMD_INV  = 4'd5;
    localparam logic [3:0] CMD_POW  = 4'd6;
    localparam logic [3:0] CMD_SQRT = 4'd7;
    localparam logic [3:0] CMD_REM  = 4'd8;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RA_INIT, ST_RA_RUN, ST_RA_TAKE,
        ST_RB_INIT, ST_RB_RUN, ST_RB_TAKE,
        ST_DISPATCH,
        ST_MUL_INIT, ST_MUL_RUN, ST_MUL_TAKE,
        ST_REM_INIT, ST_REM_RUN, ST_REM_TAKE,
        ST_EUC_INIT, ST_EUC_CHK, ST_EUC_DINIT, ST_EUC_DRUN,
        ST_EUC_MINIT, ST_EUC_MRUN, ST_EUC_UPD, ST_EUC_END,
        ST_DM_INIT, ST_DM_RUN, ST_DM_TAKE,
        ST_POW_INIT, ST_SQ_INIT, ST_SQ_RUN, ST_SQ_TAKE,
        ST_PM_INIT, ST_PM_RUN, ST_PM_TAKE, ST_POW_NEXT,
        ST_FINISH
    } t_state;

    // datapath micro operations
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_LOAD,
        MOP_DIV_START,
        MOP_DIV_STEP,
        MOP_TAKE_A,
        MOP_TAKE_B,
        MOP_MUL_START,
        MOP_MUL_STEP,
        MOP_TAKE_PROD,
        MOP_TAKE_REM,
        MOP_EUC_INIT,
        MOP_EUC_UPD,
        MOP_TAKE_T0,
        MOP_POW_INIT,
        MOP_SHIFT_E,
        MOP_FINISH
    } t_mop;

    // divider operand pairs (dividend, divisor)
    typedef enum logic [1:0] {
        DSEL_A_P,
        DSEL_B_P,
        DSEL_A_B,
        DSEL_R0_R1
    } t_div_sel;

    // multiplier operand pairs (multiplicand, scanned multiplier)
    typedef enum logic [2:0] {
        MSEL_A_B,
        MSEL_T1_Q,
        MSEL_A_T0,
        MSEL_RES_RES,
        MSEL_A_RES
    } t_mul_sel;

    // command from controller to datapath
    typedef struct packed {
        t_mop     mop;
        t_div_sel dsel;
        t_mul_sel msel;
    } t_dp_ctrl;

    // status from datapath to controller
    typedef struct packed {
        logic [3:0] cmd;
        logic       a_zero;
        logic       b_zero;
        logic       r1_zero;
        logic       e_msb;
        logic       out_busy;
    } t_dp_stat;

endpackage

[sv/prime_field_modular_alu.sv]
// top level of the prime field modular alu
//
// Usage: one input transaction carries the command in tuser and the
// operands a, b and the exponent in tdata; one output transaction carries
// the result, the second square root and three flags. The user must write
// the modulus through the write port only while the unit is idle; the
// block does not enforce this. Zero acts as one. Both operands are
// reduced mod p first by a shift-subtract divider. Add, sub and neg then
// finish. Mul then runs the double-and-add multiplier, rem the divider.
// Pow and sqrt run W exponent bits, each a squaring and at most one
// multiply. Inv and div run extended Euclid: each round is one division
// and one multiply, for up to about 1.5W rounds; div then multiplies a
// by the inverse of b.
// One item is in flight at a time; input tready is high only when idle.
// The result sits in an output register; a stalled receiver holds it
// there. The next item may be accepted and worked on meanwhile, but its
// result waits in the last step until the register has been taken.
// Reset returns the controller to idle, drops output tvalid and sets the
// modulus to one.
module prime_field_modular_alu #(
    parameter int unsigned FIELD_W = pfma_pkg::FIELD_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [63:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,  // operand_a, operand_b, exponent
    input  logic [3:0]   i_s_axis_tuser,  // command
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,  // result, second_root
    output logic [2:0]   o_m_axis_tuser   // zero_divisor, a_equals_b, a_less_b
);
    import pfma_pkg::*;

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    // sequencer
    pfma_ctrl #(.W(FIELD_W)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    // arithmetic and output register
    pfma_dpath #(.W(FIELD_W)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (i_s_axis_tuser),
        .i_a            (i_s_axis_tdata[63:0]),
        .i_b            (i_s_axis_tdata[127:64]),
        .i_e            (i_s_axis_tdata[191:128]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_result       (o_m_axis_tdata[63:0]),
        .o_second_root  (o_m_axis_tdata[127:64]),
        .o_zero_divisor (o_m_axis_tuser[0]),
        .o_a_equals_b   (o_m_axis_tuser[1]),
        .o_a_less_b     (o_m_axis_tuser[2])
    );

endmodule

[sv/pfma_ctrl.sv]
// sequencing state machine of the prime field modular alu
module pfma_ctrl #(
    parameter int unsigned W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pfma_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output pfma_pkg::t_dp_ctrl o_ctrl
);
    import pfma_pkg::*;

    localparam int unsigned CW = $clog2(W);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_bit, n_bit;
    logic          w_run;
    logic          w_last;

    assign w_last = (r_cnt == CW'(W - 1));

    // states that step the divider or the multiplier once per cycle
    always_comb begin
        unique case (r_state)
            ST_RA_RUN, ST_RB_RUN, ST_MUL_RUN, ST_REM_RUN, ST_EUC_DRUN,
            ST_EUC_MRUN, ST_DM_RUN, ST_SQ_RUN, ST_PM_RUN: w_run = 1'b1;
            default: w_run = 1'b0;
        endcase
    end

    // step and exponent bit counters
    always_comb begin
        n_cnt = (w_run && !w_last) ? r_cnt + 1'b1 : '0;
        n_bit = r_bit;
        if (r_state == ST_POW_INIT) begin
            n_bit = '0;
        end else if (r_state == ST_POW_NEXT) begin
            n_bit = r_bit + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_RA_INIT;
            ST_RA_INIT:   n_state = ST_RA_RUN;
            ST_RA_RUN:    if (w_last) n_state = ST_RA_TAKE;
            ST_RA_TAKE:   n_state = ST_RB_INIT;
            ST_RB_INIT:   n_state = ST_RB_RUN;
            ST_RB_RUN:    if (w_last) n_state = ST_RB_TAKE;
            ST_RB_TAKE:   n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_MUL:  n_state = ST_MUL_INIT;
                    CMD_DIV:  n_state = i_stat.b_zero ? ST_FINISH : ST_EUC_INIT;
                    CMD_INV:  n_state = i_stat.a_zero ? ST_FINISH : ST_EUC_INIT;
                    CMD_POW,
                    CMD_SQRT: n_state = ST_POW_INIT;
                    CMD_REM:  n_state = i_stat.b_zero ? ST_FINISH : ST_REM_INIT;
                    default:  n_state = ST_FINISH;
                endcase
            end
            ST_MUL_INIT:  n_state = ST_MUL_RUN;
            ST_MUL_RUN:   if (w_last) n_state = ST_MUL_TAKE;
            ST_MUL_TAKE:  n_state = ST_FINISH;
            ST_REM_INIT:  n_state = ST_REM_RUN;
            ST_REM_RUN:   if (w_last) n_state = ST_REM_TAKE;
            ST_REM_TAKE:  n_state = ST_FINISH;
            ST_EUC_INIT:  n_state = ST_EUC_CHK;
            ST_EUC_CHK:   n_state = i_stat.r1_zero ? ST_EUC_END : ST_EUC_DINIT;
            ST_EUC_DINIT: n_state = ST_EUC_DRUN;
            ST_EUC_DRUN:  if (w_last) n_state = ST_EUC_MINIT;
            ST_EUC_MINIT: n_state = ST_EUC_MRUN;
            ST_EUC_MRUN:  if (w_last) n_state = ST_EUC_UPD;
            ST_EUC_UPD:   n_state = ST_EUC_CHK;
            ST_EUC_END:   n_state = (i_stat.cmd == CMD_DIV) ? ST_DM_INIT : ST_FINISH;
            ST_DM_INIT:   n_state = ST_DM_RUN;
            ST_DM_RUN:    if (w_last) n_state = ST_DM_TAKE;
            ST_DM_TAKE:   n_state = ST_FINISH;
            ST_POW_INIT:  n_state = ST_SQ_INIT;
            ST_SQ_INIT:   n_state = ST_SQ_RUN;
            ST_SQ_RUN:    if (w_last) n_state = ST_SQ_TAKE;
            ST_SQ_TAKE:   n_state = i_stat.e_msb ? ST_PM_INIT : ST_POW_NEXT;
            ST_PM_INIT:   n_state = ST_PM_RUN;
            ST_PM_RUN:    if (w_last) n_state = ST_PM_TAKE;
            ST_PM_TAKE:   n_state = ST_POW_NEXT;
            ST_POW_NEXT:  n_state = (r_bit == CW'(W - 1)) ? ST_FINISH : ST_SQ_INIT;
            ST_FINISH:    if (!i_stat.out_busy) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctrl.mop  = MOP_NONE;
        o_ctrl.dsel = DSEL_A_P;
        o_ctrl.msel = MSEL_A_B;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.mop = MOP_LOAD;
            end
            ST_RA_INIT:   o_ctrl.mop = MOP_DIV_START;
            ST_RA_TAKE:   o_ctrl.mop = MOP_TAKE_A;
            ST_RB_INIT: begin
                o_ctrl.mop  = MOP_DIV_START;
                o_ctrl.dsel = DSEL_B_P;
            end
            ST_RB_TAKE:   o_ctrl.mop = MOP_TAKE_B;
            ST_REM_INIT: begin
                o_ctrl.mop  = MOP_DIV_START;
                o_ctrl.dsel = DSEL_A_B;
            end
            ST_EUC_DINIT: begin
                o_ctrl.mop  = MOP_DIV_START;
                o_ctrl.dsel = DSEL_R0_R1;
            end
            ST_RA_RUN, ST_RB_RUN, ST_REM_RUN, ST_EUC_DRUN: o_ctrl.mop = MOP_DIV_STEP;
            ST_MUL_RUN, ST_EUC_MRUN, ST_DM_RUN, ST_SQ_RUN, ST_PM_RUN:
                o_ctrl.mop = MOP_MUL_STEP;
            ST_MUL_INIT:  o_ctrl.mop = MOP_MUL_START;
            ST_EUC_MINIT: begin
                o_ctrl.mop  = MOP_MUL_START;
                o_ctrl.msel = MSEL_T1_Q;
            end
            ST_DM_INIT: begin
                o_ctrl.mop  = MOP_MUL_START;
                o_ctrl.msel = MSEL_A_T0;
            end
            ST_SQ_INIT: begin
                o_ctrl.mop  = MOP_MUL_START;
                o_ctrl.msel = MSEL_RES_RES;
            end
            ST_PM_INIT: begin
                o_ctrl.mop  = MOP_MUL_START;
                o_ctrl.msel = MSEL_A_RES;
            end
            ST_MUL_TAKE, ST_DM_TAKE, ST_SQ_TAKE, ST_PM_TAKE: o_ctrl.mop = MOP_TAKE_PROD;
            ST_REM_TAKE:  o_ctrl.mop = MOP_TAKE_REM;
            ST_EUC_INIT:  o_ctrl.mop = MOP_EUC_INIT;
            ST_EUC_UPD:   o_ctrl.mop = MOP_EUC_UPD;
            ST_EUC_END:   o_ctrl.mop = MOP_TAKE_T0;
            ST_POW_INIT:  o_ctrl.mop = MOP_POW_INIT;
            ST_POW_NEXT:  o_ctrl.mop = MOP_SHIFT_E;
            ST_FINISH:    if (!i_stat.out_busy) o_ctrl.mop = MOP_FINISH;
            default:      o_ctrl.mop = MOP_NONE;
        endcase
    end

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
        end
    end

endmodule

[sv/pfma_dpath.sv]
// operand registers, shift-subtract divider, double-and-add multiplier and output register
module pfma_dpath #(
    parameter int unsigned W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfma_pkg::t_dp_ctrl i_ctrl,
    output pfma_pkg::t_dp_stat o_stat,
    input  logic               i_cfg_wr_en,
    input  logic [63:0]        i_cfg_wr_data,
    input  logic [3:0]         i_cmd,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    input  logic [63:0]        i_e,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [63:0]        o_result,
    output logic [63:0]        o_second_root,
    output logic               o_zero_divisor,
    output logic               o_a_equals_b,
    output logic               o_a_less_b
);
    import pfma_pkg::*;

    // modular add of two values below p
    function automatic logic [W-1:0] f_add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                               logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[W-1:0];
    endfunction

    // modular subtract of two values below p
    function automatic logic [W-1:0] f_sub_mod(logic [W-1:0] x, logic [W-1:0] y,
                                               logic [W-1:0] p);
        return (x >= y) ? x - y : p - (y - x);
    endfunction

    logic [W-1:0] r_p;
    logic [3:0]   r_cmd;
    logic [W-1:0] r_a, r_b, r_e, r_res;
    logic [W-1:0] r_r0, r_r1, r_t0, r_t1;
    logic [W-1:0] r_dx, r_dy, r_rem;
    logic [W-1:0] r_mx, r_my, r_acc;
    logic         r_out_valid;
    logic [W-1:0] r_out_res, r_out_root;
    logic         r_out_zd, r_out_eq, r_out_lt;

    logic [W:0]   w_sh;
    logic         w_ge;
    logic [W-1:0] w_dbl, w_mstep;
    logic [W-1:0] w_q_red;
    logic [W-1:0] w_one;
    logic [W-1:0] w_fin_res, w_fin_root;
    logic         w_fin_zd;
    logic [W-1:0] w_cfg_p;

    assign w_one   = (r_p == W'(1)) ? '0 : W'(1);
    assign w_q_red = (r_dx >= r_p) ? '0 : r_dx;
    assign w_cfg_p = (i_cfg_wr_data[W-1:0] == '0) ? W'(1) : i_cfg_wr_data[W-1:0];

    // one restoring division step
    assign w_sh = {r_rem, r_dx[W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dy});

    // one double-and-add step
    always_comb begin
        w_dbl   = f_add_mod(r_acc, r_acc, r_p);
        w_mstep = r_my[W-1] ? f_add_mod(w_dbl, r_mx, r_p) : w_dbl;
    end

    // final result by command
    always_comb begin
        w_fin_res  = '0;
        w_fin_root = '0;
        w_fin_zd   = 1'b0;
        case (r_cmd)
            CMD_ADD: w_fin_res = f_add_mod(r_a, r_b, r_p);
            CMD_SUB: w_fin_res = f_sub_mod(r_a, r_b, r_p);
            CMD_NEG: w_fin_res = (r_a == '0) ? '0 : r_p - r_a;
            CMD_MUL, CMD_POW: w_fin_res = r_res;
            CMD_SQRT: begin
                w_fin_res  = r_res;
                w_fin_root = (r_res == '0) ? '0 : r_p - r_res;
            end
            CMD_DIV, CMD_REM: begin
                w_fin_zd  = (r_b == '0);
                w_fin_res = w_fin_zd ? '0 : r_res;
            end
            CMD_INV: begin
                w_fin_zd  = (r_a == '0);
                w_fin_res = w_fin_zd ? '0 : r_res;
            end
            default: w_fin_res = '0;
        endcase
    end

    // modulus register, zero stands for one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= W'(1);
        end else if (i_cfg_wr_en) begin
            r_p <= w_cfg_p;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.mop)
            MOP_LOAD: begin
                r_cmd <= i_cmd;
                r_a   <= i_a[W-1:0];
                r_b   <= i_b[W-1:0];
                r_e   <= i_e[W-1:0];
            end
            MOP_DIV_START: begin
                r_rem <= '0;
                case (i_ctrl.dsel)
                    DSEL_A_P:   begin r_dx <= r_a;  r_dy <= r_p;  end
                    DSEL_B_P:   begin r_dx <= r_b;  r_dy <= r_p;  end
                    DSEL_A_B:   begin r_dx <= r_a;  r_dy <= r_b;  end
                    default:    begin r_dx <= r_r0; r_dy <= r_r1; end
                endcase
            end
            MOP_DIV_STEP: begin
                r_rem <= w_ge ? W'(w_sh - {1'b0, r_dy}) : w_sh[W-1:0];
                r_dx  <= {r_dx[W-2:0], w_ge};
            end
            MOP_TAKE_A: r_a <= r_rem;
            MOP_TAKE_B: r_b <= r_rem;
            MOP_MUL_START: begin
                r_acc <= '0;
                case (i_ctrl.msel)
                    MSEL_A_B:     begin r_mx <= r_a;   r_my <= r_b;     end
                    MSEL_T1_Q:    begin r_mx <= r_t1;  r_my <= w_q_red; end
                    MSEL_A_T0:    begin r_mx <= r_a;   r_my <= r_t0;    end
                    MSEL_RES_RES: begin r_mx <= r_res; r_my <= r_res;   end
                    default:      begin r_mx <= r_a;   r_my <= r_res;   end
                endcase
            end
            MOP_MUL_STEP: begin
                r_acc <= w_mstep;
                r_my  <= {r_my[W-2:0], 1'b0};
            end
            MOP_TAKE_PROD: r_res <= r_acc;
            MOP_TAKE_REM:  r_res <= r_rem;
            MOP_EUC_INIT: begin
                r_r0 <= r_p;
                r_r1 <= (r_cmd == CMD_DIV) ? r_b : r_a;
                r_t0 <= '0;
                r_t1 <= w_one;
            end
            MOP_EUC_UPD: begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_t0 <= r_t1;
                r_t1 <= f_sub_mod(r_t0, r_acc, r_p);
            end
            MOP_TAKE_T0: r_res <= r_t0;
            MOP_POW_INIT: begin
                r_res <= w_one;
                if (r_cmd == CMD_SQRT) begin
                    r_e <= (r_p >> 2) + W'(r_p[1:0] == 2'b11);
                end
            end
            MOP_SHIFT_E: r_e <= {r_e[W-2:0], 1'b0};
            MOP_FINISH: begin
                r_out_res  <= w_fin_res;
                r_out_root <= w_fin_root;
                r_out_zd   <= w_fin_zd;
                r_out_eq   <= (r_a == r_b);
                r_out_lt   <= (r_a < r_b);
            end
            default: ;
        endcase
    end

    // output transaction valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.mop == MOP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.r1_zero  = (r_r1 == '0);
    assign o_stat.e_msb    = r_e[W-1];
    assign o_stat.out_busy = r_out_valid & ~i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_result       = 64'(r_out_res);
    assign o_second_root  = 64'(r_out_root);
    assign o_zero_divisor = r_out_zd;
    assign o_a_equals_b   = r_out_eq;
    assign o_a_less_b     = r_out_lt;

endmodule

[test/pfma_checker.sv]
// checker of the prime field modular alu: predicts every result and compares it
module pfma_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [63:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,
    input  logic [3:0]   i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [127:0] i_m_axis_tdata,
    input  logic [2:0]   i_m_axis_tuser,
    output int           o_pending,
    output int           o_failures
);
    import pfma_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [63:0] root2;
        logic        zero_div;
        logic        eq;
        logic        lt;
    } t_field_result;

    logic [63:0]   modulus_q;
    t_field_result awaited_results[$];
    int            failures;

    assign o_pending  = awaited_results.size();
    assign o_failures = failures;

    // field helpers, all operands below p
    function automatic logic [63:0] fsub(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        return (a >= b) ? a - b : p - (b - a);
    endfunction

    function automatic logic [63:0] fadd(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[63:0];
    endfunction

    function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, p});
    endfunction

    function automatic logic [63:0] fpow(logic [63:0] a, logic [63:0] e, logic [63:0] p);
        logic [63:0] r;
        r = 64'd1 % p;
        for (int k = 63; k >= 0; k--) begin
            r = fmul(r, r, p);
            if (e[k]) r = fmul(r, a, p);
        end
        return r;
    endfunction

    // extended euclid coefficient of a, reduced mod p
    function automatic logic [63:0] finv(logic [63:0] a, logic [63:0] p);
        logic [63:0] r0, r1, t0, t1, q, nr, nt;
        r0 = p;
        r1 = a;
        t0 = 64'd0;
        t1 = 64'd1 % p;
        while (r1 != 64'd0) begin
            q  = r0 / r1;
            nr = r0 - q * r1;
            nt = fsub(t0, fmul(q % p, t1, p), p);
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        return t0;
    endfunction

    function automatic t_field_result predict_field_op(logic [3:0] cmd, logic [63:0] a_in,
                                                       logic [63:0] b_in, logic [63:0] e);
        t_field_result res;
        logic [63:0]   p, a, b, q;
        p = (modulus_q == 64'd0) ? 64'd1 : modulus_q;
        a = a_in % p;
        b = b_in % p;
        res = '0;
        case (cmd)
            CMD_ADD: res.value = fadd(a, b, p);
            CMD_SUB: res.value = fsub(a, b, p);
            CMD_MUL: res.value = fmul(a, b, p);
            CMD_DIV: begin
                if (b == 64'd0) res.zero_div = 1'b1;
                else res.value = fmul(a, finv(b, p), p);
            end
            CMD_NEG: res.value = (p - a) % p;
            CMD_INV: begin
                if (a == 64'd0) res.zero_div = 1'b1;
                else res.value = finv(a, p);
            end
            CMD_POW: res.value = fpow(a, e, p);
            CMD_SQRT: begin
                q = (p >> 2) + (((p & 64'd3) + 64'd1) >> 2);
                res.value = fpow(a, q, p);
                res.root2 = (p - res.value) % p;
            end
            CMD_REM: begin
                if (b == 64'd0) res.zero_div = 1'b1;
                else res.value = a % b;
            end
            default: ;
        endcase
        res.eq = (a == b);
        res.lt = (a < b);
        return res;
    endfunction

    // track the modulus, predict on input transactions, compare on output ones
    always @(posedge i_clk) begin
        t_field_result exp_r, got_r;
        if (!i_rst_n) begin
            modulus_q = 64'd1;
            failures  = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_wr_en) modulus_q = i_cfg_wr_data;
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_results.push_back(predict_field_op(i_s_axis_tuser,
                    i_s_axis_tdata[63:0], i_s_axis_tdata[127:64], i_s_axis_tdata[191:128]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r = {i_m_axis_tdata[63:0], i_m_axis_tdata[127:64],
                         i_m_axis_tuser[0], i_m_axis_tuser[1], i_m_axis_tuser[2]};
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result transaction: result %h root %h flags %b",
                                 got_r.value, got_r.root2, i_m_axis_tuser);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (got_r !== exp_r) begin
                        failures++;
                        if (failures <= 10)
                            $display({"mismatch: result %h/%h root %h/%h zd %b/%b ",
                                      "eq %b/%b lt %b/%b (expected/actual)"},
                                     exp_r.value, got_r.value, exp_r.root2, got_r.root2,
                                     exp_r.zero_div, got_r.zero_div, exp_r.eq, got_r.eq,
                                     exp_r.lt, got_r.lt);
                    end
                end
            end
        end
    end

endmodule

[test/testbench.sv]
// stimulus, idling, watchdog and verdict for the prime field modular alu
module testbench;
    import pfma_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam logic [63:0] P61 = 64'h1FFF_FFFF_FFFF_FFFF;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [63:0]  cfg_wr_data = '0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [191:0] s_data = '0;
    logic [3:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [127:0] m_data;
    logic [2:0]   m_user;
    int           pending, failures;
    int           idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    int           idle_cycles = 0;
    logic [63:0]  cur_mod = 64'd1;

    always #6 i_clk = ~i_clk;

    prime_field_modular_alu dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user)
    );

    pfma_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_valid),
        .i_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .i_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .i_m_axis_tdata (m_data),
        .i_m_axis_tuser (m_user),
        .o_pending      (pending),
        .o_failures     (failures)
    );

    // receiver stalls according to the idling phase
    always @(posedge i_clk) begin
        case (idle_mode)
            2:       m_ready <= ($urandom_range(99) >= 74);
            3:       m_ready <= ($urandom_range(99) >= 23);
            default: m_ready <= 1'b1;
        endcase
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** prime_field_modular_alu: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transaction, called at a rising edge
    task automatic send_item(logic [3:0] cmd, logic [63:0] a, logic [63:0] b, logic [63:0] e);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 74 : (idle_mode == 3) ? 23 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {e, b, a};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [63:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_mod = value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // operands biased towards zero, small values, values near p and all ones
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(4))
            0:       return 64'($urandom_range(20));
            1:       return cur_mod - 64'($urandom_range(3));
            2:       return ~64'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [63:0] moduli[6];
        moduli = '{P61, 64'd7, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFC5, 64'd1000003};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus of one
        for (int i = 0; i < 6; i++)
            send_item(4'($urandom_range(15)), pick_operand(), pick_operand(),
                      {$urandom, $urandom});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_modulus(moduli[ph]);
            idle_mode = ph % 4;
            if (ph == 0) begin
                // directed corners under a mersenne prime
                send_item(CMD_ADD, '1, '1, '0);
                send_item(CMD_SUB, 64'd0, '1, '0);
                send_item(CMD_MUL, '1, P61 - 1, '0);
                send_item(CMD_DIV, 64'd9, P61, '0);
                send_item(CMD_DIV, 64'd5, 64'd3, '0);
                send_item(CMD_NEG, 64'd0, 64'd0, '0);
                send_item(CMD_NEG, 64'd1, 64'd2, '0);
                send_item(CMD_INV, 64'd0, 64'd1, '0);
                send_item(CMD_INV, '1, 64'd0, '0);
                send_item(CMD_POW, 64'd12345, 64'd0, 64'd0);
                send_item(CMD_POW, '1, 64'd0, '1);
                send_item(CMD_SQRT, 64'd4, 64'd0, '0);
                send_item(CMD_SQRT, 64'd0, 64'd0, '0);
                send_item(CMD_REM, 64'd77, P61, '0);
                send_item(CMD_REM, '1, 64'd12345, '0);
                send_item(4'd9, 64'd5, 64'd5 + P61, '1);
                send_item(4'd15, '1, 64'd0, '1);
                // hold off until every result is back
                s_valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
                send_item(CMD_ADD, 64'd3, 64'd4, '0);
            end
            for (int i = 0; i < 16; i++)
                send_item(4'($urandom_range(15)), pick_operand(), pick_operand(),
                          {$urandom, $urandom});
            drain();
        end

        if (failures == 0) begin
            $display("** prime_field_modular_alu: PASSED **");
        end else begin
            $display("** prime_field_modular_alu: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
sv/pfma_pkg.sv
sv/pfma_ctrl.sv
sv/pfma_dpath.sv
sv/prime_field_modular_alu.sv
test/pfma_checker.sv
test/testbench.sv
